// ===== hdl/tmeb_pkg.sv =====
// Shared types and constants of the timestamp merge event builder.
// No dependencies; imported by every module of the block.
package tmeb_pkg;

  localparam int NUM_BOARDS = 16;
  localparam int BRD_W      = 4;
  localparam int NB_W       = 5;
  localparam int MAX_HITS   = 64;
  localparam int ADDR_W     = $clog2(MAX_HITS);
  localparam int FILL_W     = $clog2(MAX_HITS + 1);
  localparam int CMDQ_DEPTH = 2;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_BOARDS = 2'd1;

  typedef struct packed {
    logic        action;
    logic [3:0]  board;
    logic [5:0]  channel;
    logic [15:0] energy;
    logic [47:0] hit_time;
    logic [15:0] low_flags;
    logic [15:0] high_flags;
  } in_t;

  typedef struct packed {
    logic [31:0] event_number;
    logic [5:0]  hit_index;
    logic [3:0]  out_board;
    logic [5:0]  out_channel;
    logic [15:0] out_energy;
    logic [47:0] out_time;
    logic [15:0] out_low_flags;
    logic [15:0] out_high_flags;
    logic        overflowed;
    logic        protocol_error;
    logic        last_of_event;
  } out_t;

  typedef struct packed {
    logic [3:0]  board;
    logic [5:0]  channel;
    logic [15:0] energy;
    logic [47:0] hit_time;
    logic [15:0] low_flags;
    logic [15:0] high_flags;
  } hit_t;

  typedef enum logic [1:0] {
    CMD_REJECT,
    CMD_ABSORB,
    CMD_FLUSH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    hit_t      hit;
  } cmd_t;

endpackage

// ===== hdl/tmeb_front.sv =====
// Front end: head slots per board, item checks and the earliest-head scan.
// Depends on tmeb_pkg; feeds merge commands to the command queue.
module tmeb_front import tmeb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  in_t             in_data,
  input  logic [NB_W-1:0] boards_in_use,
  input  logic            cmd_full,
  output logic            cmd_push,
  output cmd_t            cmd_data
);

  typedef enum logic [1:0] {F_IDLE, F_SCAN, F_LAST, F_DECIDE} fstate_t;

  fstate_t                state_r;
  logic [NUM_BOARDS-1:0]  hv_r;
  logic [NUM_BOARDS-1:0]  ret_r;
  hit_t                   head_mem [NUM_BOARDS];
  hit_t                   rd_hit_r;
  logic [BRD_W-1:0]       rd_i_r;
  logic                   rd_v_r;
  logic [BRD_W-1:0]       idx_r;
  logic                   waiting_r;
  logic                   found_r;
  logic [BRD_W-1:0]       best_r;
  hit_t                   best_hit_r;

  logic [NB_W-1:0]        nb;
  logic [NUM_BOARDS-1:0]  live_mask;
  logic                   accept;
  logic                   reject;
  logic                   all_ret;
  logic                   take;
  hit_t                   new_hit;

  assign nb = (boards_in_use > NB_W'(NUM_BOARDS)) ? NB_W'(NUM_BOARDS) : boards_in_use;

  always_comb begin
    for (int i = 0; i < NUM_BOARDS; i++) begin
      live_mask[i] = (NB_W'(i) < nb);
    end
  end

  assign full    = !(state_r == F_IDLE && !cmd_full);
  assign accept  = push && !full;
  assign reject  = ({1'b0, in_data.board} >= nb) || ret_r[in_data.board] ||
                   hv_r[in_data.board];
  assign all_ret = &(ret_r | ~live_mask);
  assign take    = !waiting_r && found_r;

  always_comb begin
    new_hit.board      = in_data.board;
    new_hit.channel    = in_data.channel;
    new_hit.energy     = in_data.energy;
    new_hit.hit_time   = in_data.hit_time;
    new_hit.low_flags  = in_data.low_flags;
    new_hit.high_flags = in_data.high_flags;
  end

  always_comb begin
    cmd_push      = 1'b0;
    cmd_data.kind = CMD_REJECT;
    cmd_data.hit  = '0;
    if (state_r == F_IDLE && accept && reject) begin
      cmd_push           = 1'b1;
      cmd_data.hit.board = in_data.board;
    end else if (state_r == F_DECIDE && !cmd_full) begin
      if (take) begin
        cmd_push           = 1'b1;
        cmd_data.kind      = CMD_ABSORB;
        cmd_data.hit       = best_hit_r;
        cmd_data.hit.board = best_r;
      end else if (all_ret) begin
        cmd_push      = 1'b1;
        cmd_data.kind = CMD_FLUSH;
      end
    end
  end

  // head slot storage
  always_ff @(posedge clk) begin
    if (accept && !reject && !in_data.action) begin
      head_mem[in_data.board] <= new_hit;
    end
    rd_hit_r <= head_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      hv_r    <= '0;
      ret_r   <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      rd_v_r <= (state_r == F_SCAN);
      rd_i_r <= idx_r;
      // compare the head read in the previous cycle
      if (rd_v_r) begin
        if (!ret_r[rd_i_r] && !hv_r[rd_i_r]) begin
          waiting_r <= 1'b1;
        end
        if (hv_r[rd_i_r] && (!found_r || rd_hit_r.hit_time <= best_hit_r.hit_time)) begin
          found_r    <= 1'b1;
          best_r     <= rd_i_r;
          best_hit_r <= rd_hit_r;
        end
      end
      unique case (state_r)
        F_IDLE: begin
          if (accept && !reject) begin
            if (!in_data.action) begin
              hv_r[in_data.board] <= 1'b1;
            end else begin
              ret_r[in_data.board] <= 1'b1;
            end
            waiting_r <= 1'b0;
            found_r   <= 1'b0;
            idx_r     <= '0;
            state_r   <= F_SCAN;
          end
        end
        F_SCAN: begin
          if ({1'b0, idx_r} == nb - 1'b1) begin
            state_r <= F_LAST;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        F_LAST: begin
          state_r <= F_DECIDE;
        end
        F_DECIDE: begin
          if (!cmd_full) begin
            if (take) begin
              hv_r[best_r] <= 1'b0;
            end
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/tmeb_cmd_fifo.sv =====
// Short command queue between the merge front end and the event back end.
// Depends on tmeb_pkg for the command type.
module tmeb_cmd_fifo import tmeb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             q_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end

endmodule

// ===== hdl/tmeb_back.sv =====
// Back end: event buffer, coincidence window test, run emission, result queue.
// Depends on tmeb_pkg; consumes commands from the command queue.
module tmeb_back import tmeb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_empty,
  input  cmd_t        cmd_data,
  output logic        cmd_pop,
  input  logic [31:0] window_ticks,
  output logic        empty,
  input  logic        pop,
  output out_t        out_data
);

  typedef enum logic [1:0] {B_IDLE, B_RD, B_WR} bstate_t;

  bstate_t           state_r;
  hit_t              ev_mem [MAX_HITS];
  hit_t              ev_rd_r;
  logic [FILL_W-1:0] fill_r;
  logic              ovf_r;
  logic [31:0]       cnt_r;
  logic [47:0]       first_r;
  logic [ADDR_W-1:0] k_r;
  logic              pend_r;
  hit_t              pend_hit_r;

  out_t              oq_r [2];
  logic              oq_wp_r;
  logic              oq_rp_r;
  logic [1:0]        oq_cnt_r;
  logic              oq_full;
  logic              oq_push;
  logic              oq_pop;
  out_t              oq_rec;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  hit_t              wdata;
  logic [47:0]       t;
  logic              in_win;
  logic              last_k;

  assign t       = cmd_data.hit.hit_time;
  assign in_win  = (t >= first_r) && ((t - first_r) < {16'b0, window_ticks});
  assign last_k  = (FILL_W'(k_r) + 1'b1 == fill_r);
  assign oq_full = (oq_cnt_r == 2'd2);
  assign empty   = (oq_cnt_r == 2'd0);
  assign oq_pop  = pop && !empty;
  assign out_data = oq_r[oq_rp_r];

  always_comb begin
    cmd_pop = 1'b0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = cmd_data.hit;
    oq_push = 1'b0;
    oq_rec  = '0;
    unique case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd_data.kind)
            CMD_REJECT: begin
              if (!oq_full) begin
                cmd_pop               = 1'b1;
                oq_push               = 1'b1;
                oq_rec.out_board      = cmd_data.hit.board;
                oq_rec.protocol_error = 1'b1;
              end
            end
            CMD_ABSORB: begin
              cmd_pop = 1'b1;
              if (fill_r == '0) begin
                we = 1'b1;
              end else if (in_win && fill_r < FILL_W'(MAX_HITS)) begin
                we    = 1'b1;
                waddr = ADDR_W'(fill_r);
              end
            end
            CMD_FLUSH: cmd_pop = 1'b1;
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      B_WR: begin
        if (!oq_full) begin
          oq_push               = 1'b1;
          oq_rec.event_number   = cnt_r;
          oq_rec.hit_index      = 6'(k_r);
          oq_rec.out_board      = ev_rd_r.board;
          oq_rec.out_channel    = ev_rd_r.channel;
          oq_rec.out_energy     = ev_rd_r.energy;
          oq_rec.out_time       = ev_rd_r.hit_time;
          oq_rec.out_low_flags  = ev_rd_r.low_flags;
          oq_rec.out_high_flags = ev_rd_r.high_flags;
          oq_rec.overflowed     = ovf_r;
          oq_rec.last_of_event  = last_k;
          // open the pending event once the old one is out
          if (last_k && pend_r) begin
            we    = 1'b1;
            wdata = pend_hit_r;
          end
        end
      end
      default: ;
    endcase
  end

  // event buffer
  always_ff @(posedge clk) begin
    if (we) begin
      ev_mem[waddr] <= wdata;
    end
    ev_rd_r <= ev_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!cmd_empty && cmd_data.kind == CMD_ABSORB) begin
            if (fill_r == '0) begin
              fill_r  <= FILL_W'(1);
              ovf_r   <= 1'b0;
              first_r <= t;
            end else if (in_win) begin
              if (fill_r < FILL_W'(MAX_HITS)) begin
                fill_r <= fill_r + 1'b1;
              end else begin
                ovf_r <= 1'b1;
              end
            end else begin
              pend_r     <= 1'b1;
              pend_hit_r <= cmd_data.hit;
              k_r        <= '0;
              state_r    <= B_RD;
            end
          end else if (!cmd_empty && cmd_data.kind == CMD_FLUSH && fill_r != '0) begin
            pend_r  <= 1'b0;
            k_r     <= '0;
            state_r <= B_RD;
          end
        end
        B_RD: state_r <= B_WR;
        B_WR: begin
          if (!oq_full) begin
            if (last_k) begin
              cnt_r   <= cnt_r + 1'b1;
              ovf_r   <= 1'b0;
              state_r <= B_IDLE;
              if (pend_r) begin
                fill_r  <= FILL_W'(1);
                first_r <= pend_hit_r.hit_time;
              end else begin
                fill_r <= '0;
              end
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= B_RD;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wp_r] <= oq_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wp_r <= ~oq_wp_r;
      end
      if (oq_pop) begin
        oq_rp_r <= ~oq_rp_r;
      end
      oq_cnt_r <= oq_cnt_r + 2'(oq_push) - 2'(oq_pop);
    end
  end

endmodule

// ===== hdl/timestamp_merge_event_builder.sv =====
// Top level of the timestamp merge event builder: config registers and wiring.
// Depends on tmeb_pkg, tmeb_front, tmeb_cmd_fifo and tmeb_back.
//
// Hit records from up to 16 boards enter through a queue-style port (push/full)
// and land in a one-slot head per board. Once every live board holds a head,
// the earliest head (ties to the highest board) is merged into the open event;
// a hit outside the coincidence window closes the event, which leaves as a run
// of records on the result queue (empty/pop) followed by the start of a new
// event. An end mark retires a board; retiring the last one flushes the open
// event. Rejected items give one record with protocol_error set. A rejected
// item leaves the front end idle, so the input stays free unless the command
// queue is full. Any other transfer blocks the input while the front end scans
// the head slots through their single read port and then decides; a full
// command queue stretches this. Emitting an event reads each hit through the
// event buffer read port in a read state and a write state, overlapped with
// the front end through a two-entry command queue.
// Write window_ticks and boards_in_use only while the block is idle.
module timestamp_merge_event_builder import tmeb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_t         in_data,
  output logic        empty,
  input  logic        pop,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]     window_r;
  logic [NB_W-1:0] boards_r;
  logic            cmd_push;
  cmd_t            cmd_wdata;
  logic            cmd_full;
  logic            cmd_pop;
  cmd_t            cmd_rdata;
  logic            cmd_empty;

  // config writes are always accepted; cfg_ready is tied high
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= 32'd100;
      boards_r <= NB_W'(NUM_BOARDS);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW: window_r <= cfg_data;
        REG_BOARDS: boards_r <= cfg_data[NB_W-1:0];
        default: ;
      endcase
    end
  end

  tmeb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_data       (in_data),
    .boards_in_use (boards_r),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_wdata)
  );

  tmeb_cmd_fifo u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wdata),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rdata),
    .empty   (cmd_empty)
  );

  tmeb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_empty    (cmd_empty),
    .cmd_data     (cmd_rdata),
    .cmd_pop      (cmd_pop),
    .window_ticks (window_r),
    .empty        (empty),
    .pop          (pop),
    .out_data     (out_data)
  );

endmodule
